### rtl/core/alet_pkg.sv
// shared types, constants and register codes of the audio level envelope tracker
package alet_pkg;

  localparam int LVL_W       = 15;
  localparam int MS_W        = 16;
  localparam int IDX_W       = 4;
  localparam int SIGNALS     = 4;
  localparam int WINDOWS_DEF = 3;
  localparam int DIV_STEPS   = LVL_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [LVL_W-1:0] AVG_RESET = LVL_W'(1638);
  localparam logic [LVL_W-1:0] MAX_RESET = LVL_W'(3277);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_WIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_WIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_WIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_DECAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DECAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_DECAY = 3'd5;

  localparam logic [MS_W-1:0] LONG_WIN_RESET    = 16'd4000;
  localparam logic [MS_W-1:0] MID_WIN_RESET     = 16'd1000;
  localparam logic [MS_W-1:0] SHORT_WIN_RESET   = 16'd200;
  localparam logic [MS_W-1:0] LONG_DECAY_RESET  = 16'd65347;
  localparam logic [MS_W-1:0] MID_DECAY_RESET   = 16'd64783;
  localparam logic [MS_W-1:0] SHORT_DECAY_RESET = 16'd61858;

  typedef struct packed {
    logic [LVL_W-1:0] low_band_level;
    logic [LVL_W-1:0] mid_band_level;
    logic [LVL_W-1:0] high_band_level;
    logic [LVL_W-1:0] loudness_level;
    logic [MS_W-1:0]  delta_ms;
  } frame_t;

  typedef struct packed {
    logic [IDX_W-1:0] tracker_index;
    logic [LVL_W-1:0] smoothed_level;
    logic [LVL_W-1:0] floor_level;
    logic [LVL_W-1:0] mean_level;
    logic [LVL_W-1:0] ceiling_level;
    logic             above_ceiling;
    logic             below_floor;
    logic             peak_ended;
    logic             last_result;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SMOOTH,
    S_MUL,
    S_SUM,
    S_DIV,
    S_DMUL,
    S_DFIN,
    S_HAND
  } seq_state_t;

  typedef struct packed {
    logic       take;
    seq_state_t phase;
  } lane_ctl_t;

endpackage

### rtl/core/alet_lane.sv
// one tracker lane: smoothing, windowed average with serial divide, min/max decay
module alet_lane #(
  parameter logic [alet_pkg::IDX_W-1:0] IDX     = '0,
  parameter bit                         IS_LAST = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  alet_pkg::lane_ctl_t           ctl,
  input  logic [alet_pkg::LVL_W-1:0]    level,
  input  logic [alet_pkg::MS_W-1:0]     elapsed,
  input  logic [alet_pkg::MS_W-1:0]     win,
  input  logic [alet_pkg::MS_W-1:0]     decay,
  output alet_pkg::result_t             res
);
  import alet_pkg::*;

  logic [LVL_W-1:0] cur_r, prev_r, avg_r, min_r, max_r;
  logic             flag_r;
  logic [LVL_W-1:0] level_r, s_r;
  logic [MS_W-1:0]  el_r, inv_r;
  logic             used_r;
  logic [30:0]      pa_r, pb_r, pm_r, pn_r;
  logic [31:0]      qa_r;
  logic [MS_W-1:0]  rem_r;
  logic [LVL_W-1:0] qn_r;
  result_t          res_r;

  logic [MS_W:0]    sum_lvl;
  logic [LVL_W-1:0] s_nxt;
  logic [32:0]      acc;
  logic [MS_W:0]    trial;
  logic             qbit;
  logic [LVL_W-1:0] avg_sel;
  logic [MS_W:0]    dinv;
  logic [32:0]      mx_acc, mn_acc;
  logic [LVL_W-1:0] mx_dec, mn_dec, mx_cl, mn_cl;
  logic             above, below;

  always_comb begin
    sum_lvl = {1'b0, level_r} + {1'b0, prev_r};
    s_nxt   = sum_lvl[LVL_W:1];
    acc     = 33'(pa_r) + 33'(pb_r) + 33'(win[MS_W-1:1]);
    trial   = {rem_r, qn_r[LVL_W-1]};
    qbit    = (trial >= {1'b0, win});
    avg_sel = used_r ? s_r : qn_r;
    dinv    = 17'h10000 - {1'b0, decay};
    mx_acc  = 33'(pm_r) + 33'(qa_r) + 33'(32768);
    mn_acc  = 33'(pn_r) + 33'(qa_r) + 33'(32768);
    mx_dec  = mx_acc[30:16];
    mn_dec  = mn_acc[30:16];
    mx_cl   = (mx_dec < avg_r) ? avg_r : mx_dec;
    mn_cl   = (mn_dec > avg_r) ? avg_r : mn_dec;
    above   = (s_r > mx_cl);
    below   = (s_r < mn_cl);
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      prev_r <= '0;
      avg_r  <= AVG_RESET;
      min_r  <= '0;
      max_r  <= MAX_RESET;
      flag_r <= 1'b0;
    end else begin
      if (ctl.phase == S_SMOOTH) begin
        prev_r <= cur_r;
        cur_r  <= s_nxt;
      end
      if (ctl.phase == S_DMUL) begin
        avg_r <= avg_sel;
      end
      if (ctl.phase == S_DFIN) begin
        min_r  <= below ? s_r : mn_cl;
        max_r  <= above ? s_r : mx_cl;
        flag_r <= above;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      level_r <= level;
      el_r    <= elapsed;
    end
    case (ctl.phase)
      S_SMOOTH: begin
        s_r    <= s_nxt;
        used_r <= (el_r >= win);
        inv_r  <= win - el_r;
      end
      S_MUL: begin
        pa_r <= 31'(avg_r) * 31'(inv_r);
        pb_r <= 31'(s_r) * 31'(el_r);
      end
      S_SUM: begin
        // quotient fits 15 bits, so the upper part already sits below the window
        rem_r <= acc[30:15];
        qn_r  <= acc[14:0];
      end
      S_DIV: begin
        rem_r <= qbit ? MS_W'(trial - {1'b0, win}) : trial[MS_W-1:0];
        qn_r  <= {qn_r[LVL_W-2:0], qbit};
      end
      S_DMUL: begin
        pm_r <= 31'(max_r) * 31'(decay);
        pn_r <= 31'(min_r) * 31'(decay);
        qa_r <= 32'(avg_sel) * 32'(dinv);
      end
      S_DFIN: begin
        res_r.tracker_index  <= IDX;
        res_r.smoothed_level <= s_r;
        res_r.floor_level    <= below ? s_r : mn_cl;
        res_r.mean_level     <= avg_r;
        res_r.ceiling_level  <= above ? s_r : mx_cl;
        res_r.above_ceiling  <= above;
        res_r.below_floor    <= below;
        res_r.peak_ended     <= flag_r & ~above;
        res_r.last_result    <= IS_LAST;
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule

### rtl/core/alet_merge.sv
// result bank that takes all lane results of a frame and streams them out in order
module alet_merge #(
  parameter int TRACKERS = alet_pkg::SIGNALS * alet_pkg::WINDOWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  alet_pkg::result_t lane_res [TRACKERS],
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output alet_pkg::result_t out_data
);
  import alet_pkg::*;

  localparam int IW = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;

  result_t         bank_r [TRACKERS];
  logic            full_r, full_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            xfer;

  always_comb begin
    xfer     = full_r & ~out_stall;
    full_nxt = full_r;
    idx_nxt  = idx_r;
    if (load) begin
      full_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (xfer) begin
      if (idx_r == IW'(TRACKERS - 1)) begin
        full_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      full_r <= full_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank_r <= lane_res;
    end
  end

  assign full      = full_r;
  assign out_valid = full_r;
  assign out_data  = bank_r[idx_r];

endmodule

### rtl/core/audio_level_envelope_tracker.sv
// Audio level envelope tracker. Each accepted frame on the in_ channel carries
// four Q0.15 levels and the elapsed time; it yields one result per tracker
// (signal times WINDOWS plus window) on the out_ channel, in tracker order,
// with last_result set on the final one. Both channels use valid/stall: a
// transaction happens when valid is high and stall is low.
// All trackers run as parallel lanes in lockstep through smooth, multiply,
// sum, a restoring divide, decay multiply and finish; a handoff state then
// hands the results to the output bank once it is empty, and the bank's
// registered full flag drives out_valid. The next frame is accepted as soon
// as the bank has taken the results, while the bank drains one result per
// cycle in parallel when out_stall is low; if the receiver stalls long enough
// that the bank still holds the previous frame, in_stall stays high until it
// empties. Stalled results hold steady.
// cfg_ writes (always ready) set windows and decays; write only while idle.
// Synchronous reset restores the register defaults and all tracker state;
// there is no clearing pass.
module audio_level_envelope_tracker #(
  parameter int WINDOWS = alet_pkg::WINDOWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  alet_pkg::frame_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output alet_pkg::result_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [alet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import alet_pkg::*;

  localparam int TRACKERS = SIGNALS * WINDOWS;

  logic [MS_W-1:0] long_win_r, mid_win_r, short_win_r;
  logic [MS_W-1:0] long_dec_r, mid_dec_r, short_dec_r;

  seq_state_t        state_r, state_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  lane_ctl_t         ctl;
  logic              accept;
  logic              mg_load;
  logic              mg_full;
  logic [LVL_W-1:0]  lvl [SIGNALS];
  result_t           lane_res [TRACKERS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_win_r  <= LONG_WIN_RESET;
      mid_win_r   <= MID_WIN_RESET;
      short_win_r <= SHORT_WIN_RESET;
      long_dec_r  <= LONG_DECAY_RESET;
      mid_dec_r   <= MID_DECAY_RESET;
      short_dec_r <= SHORT_DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_WIN:    long_win_r  <= cfg_data;
        REG_MID_WIN:     mid_win_r   <= cfg_data;
        REG_SHORT_WIN:   short_win_r <= cfg_data;
        REG_LONG_DECAY:  long_dec_r  <= cfg_data;
        REG_MID_DECAY:   mid_dec_r   <= cfg_data;
        REG_SHORT_DECAY: short_dec_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    in_stall  = 1'b1;
    mg_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_SMOOTH;
        end
      end
      S_SMOOTH: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_SUM;
      S_SUM: begin
        state_nxt = S_DIV;
        dcnt_nxt  = '0;
      end
      S_DIV: begin
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DMUL;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      S_DMUL: state_nxt = S_DFIN;
      S_DFIN: state_nxt = S_HAND;
      S_HAND: begin
        if (!mg_full) begin
          mg_load   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ctl.take  = accept;
  assign ctl.phase = state_r;

  assign lvl[0] = in_data.low_band_level;
  assign lvl[1] = in_data.mid_band_level;
  assign lvl[2] = in_data.high_band_level;
  assign lvl[3] = in_data.loudness_level;

  for (genvar k = 0; k < TRACKERS; k++) begin : g_lane
    localparam int SIG = k / WINDOWS;
    localparam int WIN = k % WINDOWS;
    logic [MS_W-1:0] lane_win, lane_dec;

    // windows past the third share the short registers
    assign lane_win = (WIN == 0) ? long_win_r : (WIN == 1) ? mid_win_r : short_win_r;
    assign lane_dec = (WIN == 0) ? long_dec_r : (WIN == 1) ? mid_dec_r : short_dec_r;

    alet_lane #(
      .IDX     (IDX_W'(k)),
      .IS_LAST (k == TRACKERS - 1)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .level   (lvl[SIG]),
      .elapsed (in_data.delta_ms),
      .win     (lane_win),
      .decay   (lane_dec),
      .res     (lane_res[k])
    );
  end

  alet_merge #(
    .TRACKERS (TRACKERS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (mg_load),
    .lane_res  (lane_res),
    .full      (mg_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SMOOTH)
    else $error("accepted frame did not start the lanes");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mg_load |-> !out_valid)
    else $error("result bank loaded while still holding a frame");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMUL) |-> $past(state_r == S_DIV) && $past(dcnt_r) == DCNT_W'(DIV_STEPS - 1))
    else $error("divide ran a wrong number of steps");

  a_drain_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid) && $past(rst_n)) |-> $past(out_data.last_result && !out_stall))
    else $error("output stream ended before the last result");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mg_load && (state_r == S_HAND) |=> state_r == S_HAND || !out_valid ||
    state_r == S_IDLE)
    else $error("sequencer left handoff without loading the bank");
`endif

endmodule

### verif/audio_level_envelope_tracker_tb.sv
// self-checking testbench for the audio level envelope tracker
`timescale 1ns / 1ps

module audio_level_envelope_tracker_tb;
  import alet_pkg::*;

  localparam int TRACKERS = SIGNALS * WINDOWS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [LVL_W-1:0] LVL_MAX = '1;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  frame_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  audio_level_envelope_tracker dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the register file and of every tracker's state
  logic [CFG_DATA_W-1:0] reg_shadow [6];
  logic [LVL_W-1:0] cur_lvl [TRACKERS];
  logic [LVL_W-1:0] prev_lvl [TRACKERS];
  logic [LVL_W-1:0] mean_lvl [TRACKERS];
  logic [LVL_W-1:0] floor_lvl [TRACKERS];
  logic [LVL_W-1:0] ceil_lvl [TRACKERS];
  logic peak_flag [TRACKERS];

  result_t pending_results [$];
  result_t want;
  int fail_count = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_val, got_val);
  endtask

  task automatic check_field(input string what, input int exp_val, input int got_val);
    if (exp_val != got_val) report_mismatch(what, exp_val, got_val);
  endtask

  function automatic logic [LVL_W-1:0] decay_bound(input logic [LVL_W-1:0] bound,
                                                   input logic [LVL_W-1:0] avg,
                                                   input logic [MS_W-1:0] d);
    longint unsigned acc;
    acc = longint'(bound) * d + longint'(avg) * (65536 - longint'(d)) + 32768;
    return LVL_W'(acc >> 16);
  endfunction

  // advance all twelve trackers by one frame and queue the results it yields
  task automatic track_frame(input frame_t f);
    logic [LVL_W-1:0] lvl [SIGNALS];
    logic [LVL_W-1:0] s, avg, mx, mn;
    logic [MS_W-1:0] win, d;
    longint unsigned acc;
    logic above, below;
    result_t r;
    int k;
    lvl[0] = f.low_band_level;
    lvl[1] = f.mid_band_level;
    lvl[2] = f.high_band_level;
    lvl[3] = f.loudness_level;
    k = 0;
    for (int sig = 0; sig < SIGNALS; sig++) begin
      for (int w = 0; w < WINDOWS_DEF; w++) begin
        win = reg_shadow[REG_LONG_WIN + w];
        d = reg_shadow[REG_LONG_DECAY + w];
        s = LVL_W'((int'(lvl[sig]) + int'(prev_lvl[k])) >> 1);
        prev_lvl[k] = cur_lvl[k];
        cur_lvl[k] = s;
        if (f.delta_ms >= win) begin
          avg = s;
        end else begin
          acc = longint'(mean_lvl[k]) * (win - f.delta_ms) + longint'(s) * f.delta_ms
              + (win >> 1);
          avg = LVL_W'(acc / win);
        end
        mean_lvl[k] = avg;
        mx = decay_bound(ceil_lvl[k], avg, d);
        mn = decay_bound(floor_lvl[k], avg, d);
        if (mx < avg) mx = avg;
        if (mn > avg) mn = avg;
        below = s < mn;
        above = s > mx;
        floor_lvl[k] = below ? s : mn;
        ceil_lvl[k] = above ? s : mx;
        r.tracker_index = IDX_W'(k);
        r.smoothed_level = s;
        r.floor_level = floor_lvl[k];
        r.mean_level = avg;
        r.ceiling_level = ceil_lvl[k];
        r.above_ceiling = above;
        r.below_floor = below;
        r.peak_ended = peak_flag[k] && !above;
        r.last_result = (k == TRACKERS - 1);
        peak_flag[k] = above;
        pending_results.push_back(r);
        k++;
      end
    end
  endtask

  task automatic send_frame(input frame_t f);
    int gap;
    in_data <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_frame(f);
    frames_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_levels(input int lo, input int mi, input int hi, input int ld,
                             input int ms);
    frame_t f;
    f.low_band_level = LVL_W'(lo);
    f.mid_band_level = LVL_W'(mi);
    f.high_band_level = LVL_W'(hi);
    f.loudness_level = LVL_W'(ld);
    f.delta_ms = MS_W'(ms);
    send_frame(f);
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return LVL_MAX;
      default: return LVL_W'($urandom_range(32767));
    endcase
  endfunction

  // mostly short frame times so the averages blend, now and then the full range
  task automatic send_random_frame();
    frame_t f;
    f.low_band_level = pick_level();
    f.mid_band_level = pick_level();
    f.high_band_level = pick_level();
    f.loudness_level = pick_level();
    case ($urandom_range(9))
      0: f.delta_ms = MS_W'($urandom_range(65535));
      1: f.delta_ms = '0;
      default: f.delta_ms = MS_W'($urandom_range(400));
    endcase
    send_frame(f);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_SHORT_DECAY) reg_shadow[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender goes quiet until every pending result is back
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, tracker", -1, out_data.tracker_index);
      end else begin
        want = pending_results.pop_front();
        check_field("tracker_index", want.tracker_index, out_data.tracker_index);
        check_field("smoothed_level", want.smoothed_level, out_data.smoothed_level);
        check_field("floor_level", want.floor_level, out_data.floor_level);
        check_field("mean_level", want.mean_level, out_data.mean_level);
        check_field("ceiling_level", want.ceiling_level, out_data.ceiling_level);
        check_field("above_ceiling", want.above_ceiling, out_data.above_ceiling);
        check_field("below_floor", want.below_floor, out_data.below_floor);
        check_field("peak_ended", want.peak_ended, out_data.peak_ended);
        check_field("last_result", want.last_result, out_data.last_result);
        results_seen++;
      end
    end
  end

  task automatic test_reset_defaults();
    send_idle_pct = 8;
    recv_idle_pct = 52;
    send_levels(0, 0, 0, 0, 0);
    send_levels(32767, 32767, 32767, 32767, 0);
    send_levels(32767, 32767, 32767, 32767, 16);
    send_levels(0, 0, 0, 0, 65535);
    send_levels(21845, 10922, 21845, 10922, 33);
    send_levels(10922, 21845, 10922, 21845, 43690);
    quiesce();
  endtask

  // zero windows make the mean follow the level, zero decay snaps the bounds
  task automatic test_zero_window_zero_decay();
    for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(REG_LONG_WIN + i), '0);
    send_levels(32767, 0, 16384, 100, 0);
    send_levels(0, 32767, 100, 16384, 5);
    send_levels(32767, 32767, 0, 0, 0);
    send_levels(1, 2, 3, 4, 65535);
    quiesce();
  endtask

  task automatic test_extreme_registers();
    for (int i = 0; i < 6; i++) write_reg(CFG_IDX_W'(REG_LONG_WIN + i), '1);
    send_levels(32767, 32767, 32767, 32767, 65534);
    send_levels(0, 0, 0, 0, 65535);
    send_levels(32767, 0, 32767, 0, 1);
    send_levels(0, 32767, 0, 32767, 0);
    quiesce();
    write_reg(REG_LONG_WIN, 16'd1);
    write_reg(REG_MID_WIN, 16'd1);
    write_reg(REG_SHORT_WIN, 16'd1);
    send_levels(12345, 23456, 32767, 0, 0);
    quiesce();
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unused_index();
    write_reg(REG_SPARE_A, 16'h0);
    write_reg(REG_SPARE_B, '1);
    send_levels(500, 30000, 7000, 20000, 0);
    send_levels(31000, 400, 25000, 3000, 1);
    quiesce();
  endtask

  // receiver holds off while frames keep coming, so the block stalls its input
  task automatic test_backpressure();
    write_reg(REG_LONG_WIN, LONG_WIN_RESET);
    write_reg(REG_MID_WIN, MID_WIN_RESET);
    write_reg(REG_SHORT_WIN, SHORT_WIN_RESET);
    write_reg(REG_LONG_DECAY, LONG_DECAY_RESET);
    write_reg(REG_MID_DECAY, MID_DECAY_RESET);
    write_reg(REG_SHORT_DECAY, SHORT_DECAY_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 200;
    repeat (7) send_random_frame();
    quiesce();
  endtask

  task automatic randomize_registers();
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(4) == 0)
        write_reg(CFG_IDX_W'(REG_LONG_WIN + i), MS_W'($urandom_range(65535)));
      else
        write_reg(CFG_IDX_W'(REG_LONG_WIN + i), MS_W'($urandom_range(1, 3000)));
    end
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'(REG_LONG_DECAY + i), MS_W'($urandom_range(65535)));
      else
        write_reg(CFG_IDX_W'(REG_LONG_DECAY + i), MS_W'($urandom_range(55000, 65535)));
    end
  endtask

  task automatic test_random_traffic();
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 8; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 8; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < 2; ph++) begin
        randomize_registers();
        repeat (35) send_random_frame();
        quiesce();
      end
    end
  endtask

  initial begin
    reg_shadow[REG_LONG_WIN] = LONG_WIN_RESET;
    reg_shadow[REG_MID_WIN] = MID_WIN_RESET;
    reg_shadow[REG_SHORT_WIN] = SHORT_WIN_RESET;
    reg_shadow[REG_LONG_DECAY] = LONG_DECAY_RESET;
    reg_shadow[REG_MID_DECAY] = MID_DECAY_RESET;
    reg_shadow[REG_SHORT_DECAY] = SHORT_DECAY_RESET;
    for (int k = 0; k < TRACKERS; k++) begin
      cur_lvl[k] = '0;
      prev_lvl[k] = '0;
      mean_lvl[k] = AVG_RESET;
      floor_lvl[k] = '0;
      ceil_lvl[k] = MAX_RESET;
      peak_flag[k] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_window_zero_decay();
    test_extreme_registers();
    test_unused_index();
    test_backpressure();
    test_random_traffic();

    $display("covered: %0d frames, %0d tracker results checked", frames_sent, results_seen);
    $display("stimulus: reset, zero and full-scale registers, spare indexes, random phases");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
